// ===== rtl/cta_pkg.sv =====
package cta_pkg;

    localparam int HOUR_W = 5;
    localparam int MIN_W  = 6;
    localparam int SEC_W  = 6;
    localparam int CNT_W  = 6;
    localparam int CFG_W  = 6;
    localparam int IDX_W  = 2;

    localparam logic [HOUR_W-1:0] HOUR_MAX   = HOUR_W'(23);
    localparam logic [MIN_W-1:0]  MIN_MAX    = MIN_W'(59);
    localparam logic [SEC_W-1:0]  SEC_MAX    = SEC_W'(59);
    localparam logic [HOUR_W-1:0] RESET_HOUR = HOUR_W'(12);
    localparam logic [CNT_W-1:0]  RING_LIMIT = CNT_W'(60);

    typedef enum logic [2:0] {
        ACT_TICK   = 3'd0,
        ACT_LOAD   = 3'd1,
        ACT_ARM    = 3'd2,
        ACT_DISARM = 3'd3,
        ACT_STOP   = 3'd4
    } action_t;

    typedef enum logic [IDX_W-1:0] {
        REG_ALARM_A_HOUR   = 2'd0,
        REG_ALARM_A_MINUTE = 2'd1,
        REG_ALARM_B_HOUR   = 2'd2,
        REG_ALARM_B_MINUTE = 2'd3
    } reg_index_t;

    typedef struct packed {
        logic tick;
        logic load;
        logic arm;
        logic disarm;
        logic stop;
    } cta_cmd_t;

    typedef struct packed {
        logic [HOUR_W-1:0] hour;
        logic [MIN_W-1:0]  minute;
    } cta_hm_t;

endpackage

// ===== rtl/clock_with_two_alarms.sv =====
// A 24-hour clock with two alarms that takes one item per cycle while the output is not
// stalled, each item giving exactly one result that shows the time and the alarm flags
// after it. An item is held in the input register and its result is then registered in
// the output register; a new item can be taken as the last one moves on. The time and
// alarm state registers double as the output register, and a stall on the output holds
// the waiting item in the input register. The user must write the alarm registers through
// the configuration port only while no item is in flight; the block does not enforce it.
module clock_with_two_alarms
    import cta_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_write,
    input  logic [IDX_W-1:0]  cfg_index,
    input  logic [CFG_W-1:0]  cfg_data,
    input  logic              in_valid,
    output logic              in_stall,
    input  logic [2:0]        action,
    input  logic              which_alarm,
    input  logic [HOUR_W-1:0] new_hour,
    input  logic [MIN_W-1:0]  new_minute,
    input  logic [SEC_W-1:0]  new_second,
    output logic              out_valid,
    input  logic              out_stall,
    output logic [HOUR_W-1:0] hour,
    output logic [MIN_W-1:0]  minute,
    output logic [SEC_W-1:0]  second,
    output logic              ringing_a,
    output logic              ringing_b,
    output logic              armed_a,
    output logic              armed_b
);

    logic              in_full_reg, in_full_next;
    logic              out_valid_reg, out_valid_next;
    logic [2:0]        action_reg;
    logic              which_reg;
    logic [HOUR_W-1:0] new_hour_reg;
    logic [MIN_W-1:0]  new_minute_reg;
    logic [SEC_W-1:0]  new_second_reg;
    logic              step;
    logic              in_take;
    cta_cmd_t          cmd;
    cta_hm_t           tick_time;
    logic              a_hour_we, a_minute_we, b_hour_we, b_minute_we;

    assign step     = in_full_reg && (!out_valid_reg || !out_stall);
    assign in_stall = in_full_reg && !step;
    assign in_take  = in_valid && !in_stall;

    always_comb
    begin
        cmd = '0;
        unique case (action_reg)
            ACT_TICK:   cmd.tick   = 1'b1;
            ACT_LOAD:   cmd.load   = 1'b1;
            ACT_ARM:    cmd.arm    = 1'b1;
            ACT_DISARM: cmd.disarm = 1'b1;
            ACT_STOP:   cmd.stop   = 1'b1;
            default:    cmd = '0;
        endcase
    end

    always_comb
    begin
        a_hour_we   = 1'b0;
        a_minute_we = 1'b0;
        b_hour_we   = 1'b0;
        b_minute_we = 1'b0;
        unique case (cfg_index)
            REG_ALARM_A_HOUR:   a_hour_we   = cfg_write;
            REG_ALARM_A_MINUTE: a_minute_we = cfg_write;
            REG_ALARM_B_HOUR:   b_hour_we   = cfg_write;
            REG_ALARM_B_MINUTE: b_minute_we = cfg_write;
            default:            a_hour_we   = 1'b0;
        endcase
    end

    always_comb
    begin
        in_full_next = in_full_reg;
        if (in_take)
        begin
            in_full_next = 1'b1;
        end
        else if (step)
        begin
            in_full_next = 1'b0;
        end

        out_valid_next = out_valid_reg;
        if (step)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_full_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_full_reg   <= in_full_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            action_reg     <= action;
            which_reg      <= which_alarm;
            new_hour_reg   <= new_hour;
            new_minute_reg <= new_minute;
            new_second_reg <= new_second;
        end
    end

    cta_time u_time (
        .clk        (clk),
        .rst_n      (rst_n),
        .step       (step),
        .cmd        (cmd),
        .new_hour   (new_hour_reg),
        .new_minute (new_minute_reg),
        .new_second (new_second_reg),
        .tick_time  (tick_time),
        .hour       (hour),
        .minute     (minute),
        .second     (second)
    );

    cta_alarm u_alarm_a (
        .clk           (clk),
        .rst_n         (rst_n),
        .step          (step),
        .cmd           (cmd),
        .selected      (!which_reg),
        .tick_time     (tick_time),
        .cfg_hour_we   (a_hour_we),
        .cfg_minute_we (a_minute_we),
        .cfg_data      (cfg_data),
        .ringing       (ringing_a),
        .armed         (armed_a)
    );

    cta_alarm u_alarm_b (
        .clk           (clk),
        .rst_n         (rst_n),
        .step          (step),
        .cmd           (cmd),
        .selected      (which_reg),
        .tick_time     (tick_time),
        .cfg_hour_we   (b_hour_we),
        .cfg_minute_we (b_minute_we),
        .cfg_data      (cfg_data),
        .ringing       (ringing_b),
        .armed         (armed_b)
    );

    assign out_valid = out_valid_reg;

endmodule

// ===== rtl/cta_time.sv =====
module cta_time
    import cta_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              step,
    input  cta_cmd_t          cmd,
    input  logic [HOUR_W-1:0] new_hour,
    input  logic [MIN_W-1:0]  new_minute,
    input  logic [SEC_W-1:0]  new_second,
    output cta_hm_t           tick_time,
    output logic [HOUR_W-1:0] hour,
    output logic [MIN_W-1:0]  minute,
    output logic [SEC_W-1:0]  second
);

    logic [HOUR_W-1:0] hour_reg, hour_next, hour_inc;
    logic [MIN_W-1:0]  minute_reg, minute_next, minute_inc;
    logic [SEC_W-1:0]  second_reg, second_next, second_inc;

    always_comb
    begin
        second_inc = second_reg + SEC_W'(1);
        minute_inc = minute_reg;
        hour_inc   = hour_reg;
        if (second_reg >= SEC_MAX)
        begin
            second_inc = '0;
            minute_inc = minute_reg + MIN_W'(1);
            if (minute_reg >= MIN_MAX)
            begin
                minute_inc = '0;
                hour_inc   = hour_reg + HOUR_W'(1);
                if (hour_reg >= HOUR_MAX)
                begin
                    hour_inc = '0;
                end
            end
        end
    end

    always_comb
    begin
        hour_next   = hour_reg;
        minute_next = minute_reg;
        second_next = second_reg;
        if (step && cmd.tick)
        begin
            hour_next   = hour_inc;
            minute_next = minute_inc;
            second_next = second_inc;
        end
        else if (step && cmd.load)
        begin
            hour_next   = (new_hour > HOUR_MAX) ? HOUR_MAX : new_hour;
            minute_next = (new_minute > MIN_MAX) ? MIN_MAX : new_minute;
            second_next = (new_second > SEC_MAX) ? SEC_MAX : new_second;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hour_reg   <= RESET_HOUR;
            minute_reg <= '0;
            second_reg <= '0;
        end
        else
        begin
            hour_reg   <= hour_next;
            minute_reg <= minute_next;
            second_reg <= second_next;
        end
    end

    assign tick_time.hour   = hour_inc;
    assign tick_time.minute = minute_inc;
    assign hour   = hour_reg;
    assign minute = minute_reg;
    assign second = second_reg;

endmodule

// ===== rtl/cta_alarm.sv =====
module cta_alarm
    import cta_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             step,
    input  cta_cmd_t         cmd,
    input  logic             selected,
    input  cta_hm_t          tick_time,
    input  logic             cfg_hour_we,
    input  logic             cfg_minute_we,
    input  logic [CFG_W-1:0] cfg_data,
    output logic             ringing,
    output logic             armed
);

    logic [HOUR_W-1:0] cfg_hour_reg;
    logic [MIN_W-1:0]  cfg_minute_reg;
    logic              armed_reg, armed_next;
    logic              ringing_reg, ringing_next;
    logic [CNT_W-1:0]  count_reg, count_next, count_inc;
    logic              match;

    assign match = (cfg_hour_reg == tick_time.hour) && (cfg_minute_reg == tick_time.minute);
    assign count_inc = count_reg + CNT_W'(1);

    always_comb
    begin
        armed_next   = armed_reg;
        ringing_next = ringing_reg;
        count_next   = count_reg;
        if (step)
        begin
            if (cmd.tick)
            begin
                if (ringing_reg || (armed_reg && match))
                begin
                    if (count_inc == RING_LIMIT)
                    begin
                        armed_next   = 1'b0;
                        ringing_next = 1'b0;
                        count_next   = '0;
                    end
                    else
                    begin
                        ringing_next = 1'b1;
                        count_next   = count_inc;
                    end
                end
                else
                begin
                    count_next = '0;
                end
            end
            else if (cmd.arm && selected)
            begin
                armed_next = 1'b1;
            end
            else if ((cmd.disarm && selected) || (cmd.stop && ringing_reg))
            begin
                armed_next   = 1'b0;
                ringing_next = 1'b0;
                count_next   = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_hour_reg   <= '0;
            cfg_minute_reg <= '0;
            armed_reg      <= 1'b0;
            ringing_reg    <= 1'b0;
            count_reg      <= '0;
        end
        else
        begin
            if (cfg_hour_we)
            begin
                cfg_hour_reg <= cfg_data[HOUR_W-1:0];
            end
            if (cfg_minute_we)
            begin
                cfg_minute_reg <= cfg_data[MIN_W-1:0];
            end
            armed_reg   <= armed_next;
            ringing_reg <= ringing_next;
            count_reg   <= count_next;
        end
    end

    assign ringing = ringing_reg;
    assign armed   = armed_reg;

endmodule
